>>> design/lc3b_instruction_executor_defines.svh
// Assertion macros used by the checker file.
`ifndef LC3B_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define LC3B_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LC3B_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define LC3B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lc3b_pkg.sv
// Shared types, opcodes and helpers for the LC-3b executor.
`timescale 1ns / 1ps
package lc3b_pkg;

  localparam int REG_COUNT = 8;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_READ  = 2'd1,
    K_STEP  = 2'd2,
    K_NOP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDATA,
    S_DECODE,
    S_EXEC,
    S_MEM
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [14:0] word_addr;
    logic [15:0] write_data;
  } item_t;

  // First member sits in the top bits.
  typedef struct packed {
    logic        illegal;
    logic        halted;
    logic [2:0]  cond_nzp;
    logic [15:0] reg_value;
    logic [2:0]  reg_index;
    logic        reg_written;
    logic [15:0] next_pc;
    logic [15:0] read_data;
  } result_t;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LDB  = 4'd2;
  localparam logic [3:0] OP_STB  = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDW  = 4'd6;
  localparam logic [3:0] OP_STW  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_XOR  = 4'd9;
  localparam logic [3:0] OP_RSV0 = 4'd10;
  localparam logic [3:0] OP_RSV1 = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_SHF  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [1:0] SHF_LSHF  = 2'd0;
  localparam logic [1:0] SHF_RSHFL = 2'd1;
  localparam logic [1:0] SHF_KEEP  = 2'd2;
  localparam logic [1:0] SHF_RSHFA = 2'd3;

  localparam logic [2:0] FLAG_N = 3'b100;
  localparam logic [2:0] FLAG_Z = 3'b010;
  localparam logic [2:0] FLAG_P = 3'b001;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v[15]) return FLAG_N;
    else if (v == 16'h0000) return FLAG_Z;
    else return FLAG_P;
  endfunction

endpackage

>>> design/lc3b_front.sv
// Front end: classifies incoming beats and queues them for the core.
`timescale 1ns / 1ps
module lc3b_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // word_addr[14:0], write_data[30:15]
  input  logic [1:0]         s_tuser,   // func[1:0]
  input  logic               hold,      // core busy with memory clear
  output logic               q_valid,
  output lc3b_pkg::item_t    q_item,
  input  logic               q_pop
);
  import lc3b_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       in_item;

  always_comb begin
    in_item.kind       = kind_t'(s_tuser);
    in_item.word_addr  = s_tdata[14:0];
    in_item.write_data = s_tdata[30:15];
  end

  assign s_tready = (count != 2'd2) && !hold;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/lc3b_core.sv
// Back end: sequencer, register file, word memory and result register.
`timescale 1ns / 1ps
module lc3b_core #(
  parameter int MEM_WORDS = 32768
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                q_valid,
  input  lc3b_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                clearing,
  output logic                m_valid,
  input  logic                m_ready,
  output lc3b_pkg::result_t   m_result
);
  import lc3b_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  // Word index modulo MEM_WORDS by constant shift-and-subtract.
  function automatic logic [AW-1:0] wrap(input logic [14:0] w);
    logic [22:0] v;
    v = {8'b0, w};
    for (int k = 6; k >= 0; k--) begin
      if (v >= (23'(MEM_WORDS) << k)) v = v - (23'(MEM_WORDS) << k);
    end
    return v[AW-1:0];
  endfunction

  state_t state, state_next;

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0] mem_wd;
  logic [AW-1:0] clr_idx;

  logic [15:0] rf [REG_COUNT];
  logic [15:0] ra, rb;
  logic [2:0]  rf_a_addr, rf_b_addr;
  logic        rf_ld;

  logic [15:0] pc;
  logic [2:0]  flags;
  logic        halted;
  logic [15:0] ir;
  logic [15:0] ea_q;
  logic [14:0] addr_q;

  logic        can_emit, emit;
  logic [15:0] nxt_pc, val, rdat, ea;
  logic        wr, ill, halt_set, halt_cond;
  logic [2:0]  widx, flags_new;

  // decode of latched instruction
  logic [3:0]  op;
  logic [2:0]  dr, sr1;
  logic [15:0] inc, sx5, sx6, sx9, sx11, opb, byte_ld;
  logic [1:0]  shmode;
  logic [3:0]  amt;
  logic [3:0]  fop;

  assign op     = ir[15:12];
  assign dr     = ir[11:9];
  assign sr1    = ir[8:6];
  assign inc    = pc + 16'd2;
  assign sx5    = {{11{ir[4]}}, ir[4:0]};
  assign sx6    = {{10{ir[5]}}, ir[5:0]};
  assign sx9    = {{7{ir[8]}}, ir[8:0]};
  assign sx11   = {{5{ir[10]}}, ir[10:0]};
  assign opb    = ir[5] ? sx5 : rb;
  assign shmode = ir[5:4];
  assign amt    = ir[3:0];
  assign fop    = mem_q[15:12];
  assign byte_ld = ea_q[0] ? {{8{mem_q[15]}}, mem_q[15:8]} : {{8{mem_q[7]}}, mem_q[7:0]};

  assign can_emit  = !m_valid || m_ready;
  assign halt_cond = halted || (pc == 16'h0000);
  assign clearing  = (state == S_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_idx == AW'(MEM_WORDS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (q_valid && q_item.kind == K_READ) state_next = S_RDATA;
        else if (q_valid && q_item.kind == K_STEP && !halt_cond) state_next = S_DECODE;
      end
      S_RDATA:  if (can_emit) state_next = S_IDLE;
      S_DECODE: state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_LDB || op == OP_LDW || op == OP_TRAP || op == OP_STB)
          state_next = S_MEM;
        else if (can_emit) state_next = S_IDLE;
      end
      S_MEM:    if (can_emit) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = clr_idx;
    mem_wd    = 16'h0000;
    q_pop     = 1'b0;
    emit      = 1'b0;
    nxt_pc    = pc;
    wr        = 1'b0;
    widx      = 3'd0;
    val       = 16'h0000;
    rdat      = 16'h0000;
    ill       = 1'b0;
    halt_set  = 1'b0;
    flags_new = flags;
    ea        = 16'h0000;
    rf_ld     = 1'b0;
    rf_a_addr = mem_q[8:6];
    rf_b_addr = (fop == OP_STB || fop == OP_STW || fop == OP_SHF) ? mem_q[11:9] : mem_q[2:0];
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        mem_addr = wrap(q_item.word_addr);
        mem_wd   = q_item.write_data;
        if (q_valid) begin
          unique case (q_item.kind)
            K_WRITE: begin
              q_pop  = can_emit;
              emit   = can_emit;
              mem_we = can_emit;
            end
            K_READ: q_pop = 1'b1;
            K_STEP: begin
              mem_addr = wrap(pc[15:1]);
              if (halt_cond) begin
                q_pop    = can_emit;
                emit     = can_emit;
                halt_set = 1'b1;
              end else begin
                q_pop = 1'b1;
              end
            end
            default: begin
              q_pop = can_emit;
              emit  = can_emit;
            end
          endcase
        end
      end
      S_RDATA: begin
        mem_addr = wrap(addr_q);
        emit     = can_emit;
        rdat     = mem_q;
      end
      S_DECODE: rf_ld = 1'b1;
      S_EXEC: begin
        nxt_pc = inc;
        unique case (op)
          OP_ADD, OP_AND, OP_XOR: begin
            wr   = 1'b1;
            widx = dr;
            val  = (op == OP_ADD) ? ra + opb : (op == OP_AND) ? (ra & opb) : (ra ^ opb);
            flags_new = flags_of(val);
          end
          OP_BR: if ((dr & flags) != 3'b000) nxt_pc = inc + {sx9[14:0], 1'b0};
          OP_JMP: nxt_pc = ra;
          OP_JSR: begin
            nxt_pc = ir[11] ? inc + {sx11[14:0], 1'b0} : ra;
            wr     = 1'b1;
            widx   = 3'd7;
            val    = inc;
          end
          OP_LEA: begin
            wr   = 1'b1;
            widx = dr;
            val  = inc + {sx9[14:0], 1'b0};
          end
          OP_SHF: begin
            unique case (shmode)
              SHF_LSHF:  val = ra << amt;
              SHF_RSHFL: val = ra >> amt;
              SHF_RSHFA: val = 16'($signed(ra) >>> amt);
              default:   val = 16'h0000;
            endcase
            if (shmode == SHF_KEEP) begin
              flags_new = flags_of(rb);
            end else begin
              wr        = 1'b1;
              widx      = dr;
              flags_new = flags_of(val);
            end
          end
          OP_LDB, OP_STB: begin
            ea       = ra + sx6;
            mem_addr = wrap(ea[15:1]);
          end
          OP_LDW: begin
            ea       = ra + {sx6[14:0], 1'b0};
            mem_addr = wrap(ea[15:1]);
          end
          OP_TRAP: begin
            ea       = {7'b0, ir[7:0], 1'b0};
            mem_addr = wrap(ea[15:1]);
          end
          OP_STW: begin
            ea       = ra + {sx6[14:0], 1'b0};
            mem_addr = wrap(ea[15:1]);
            mem_wd   = rb;
            mem_we   = can_emit;
          end
          OP_RSV0, OP_RSV1: begin
            ill    = 1'b1;
            nxt_pc = pc;
          end
          default: nxt_pc = inc;   // RTI
        endcase
        if (!(op == OP_LDB || op == OP_LDW || op == OP_TRAP || op == OP_STB))
          emit = can_emit;
      end
      S_MEM: begin
        mem_addr = wrap(ea_q[15:1]);
        nxt_pc   = inc;
        emit     = can_emit;
        unique case (op)
          OP_LDB: begin
            wr = 1'b1; widx = dr; val = byte_ld; flags_new = flags_of(byte_ld);
          end
          OP_LDW: begin
            wr = 1'b1; widx = dr; val = mem_q; flags_new = flags_of(mem_q);
          end
          OP_TRAP: begin
            wr = 1'b1; widx = 3'd7; val = inc; nxt_pc = mem_q;
          end
          default: begin   // STB: merge one byte
            mem_we = can_emit;
            mem_wd = ea_q[0] ? {rb[7:0], mem_q[7:0]} : {mem_q[15:8], rb[7:0]};
          end
        endcase
      end
      default: mem_we = 1'b0;
    endcase
  end

  // word memory, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  // register file: two registered reads, one write at retire
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) rf[i] <= 16'h0000;
    end else if (emit && wr) begin
      rf[widx] <= val;
    end
    if (rf_ld) begin
      ra <= rf[rf_a_addr];
      rb <= rf[rf_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) ir <= mem_q;
    if (state == S_EXEC) ea_q <= ea;
    if (q_pop) addr_q <= q_item.word_addr;
    if (emit) begin
      m_result.read_data   <= rdat;
      m_result.next_pc     <= nxt_pc;
      m_result.reg_written <= wr;
      m_result.reg_index   <= wr ? widx : 3'd0;
      m_result.reg_value   <= wr ? val : 16'h0000;
      m_result.cond_nzp    <= flags_new;
      m_result.halted      <= halt_set | halted;
      m_result.illegal     <= ill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      pc      <= 16'h0000;
      flags   <= FLAG_Z;
      halted  <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + AW'(1);
      if (emit) begin
        pc    <= nxt_pc;
        flags <= flags_new;
        if (halt_set) halted <= 1'b1;
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (cfg_we) begin
        pc <= cfg_data;
        if (cfg_data != 16'h0000) halted <= 1'b0;
      end
    end
  end

endmodule

>>> design/lc3b_instruction_executor.sv
// Top level of the LC-3b instruction executor.
`timescale 1ns / 1ps
// LC-3b core with its word memory inside, driven by a request stream.
// s_* channel: one beat per request; tuser carries func (write word,
//   read word, step one instruction, no-op), tdata the word address and data.
// m_* channel: exactly one result beat per request, in request order.
// cfg_*: writes start_pc; the program counter is loaded with it and a
//   nonzero value clears the halt flag. Write only when the block is idle.
// Sequence: a write completes in S_IDLE; a read passes S_IDLE, S_RDATA;
//   a step S_IDLE, S_DECODE, S_EXEC, plus S_MEM for LDB/LDW/STB/TRAP.
// Throughput: a front queue of two beats feeds the core, so requests are
//   taken while the core works; the core retires a write every cycle while
//   the receiver takes results, and ends each read or step before the next
//   request; the single port of the word memory serves fetch, then data access.
// Reset: rst is synchronous. After reset the core sweeps the memory to
//   zero, one word per cycle; s_tready stays low while the sweep runs.
//   cfg writes are taken at any time.
// Stall: the result register holds while m_tready is low; the core waits
//   and the queue keeps taking beats until it is full.
module lc3b_instruction_executor #(
  parameter int MEM_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // word_addr[14:0], write_data[30:15], zero fill
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // read_data, next_pc, reg_written, reg_index,
                                 // reg_value, cond_nzp, halted, illegal, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import lc3b_pkg::*;

  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  logic    clearing;
  result_t result;

  assign cfg_ready = 1'b1;

  lc3b_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .hold     (clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lc3b_core #(.MEM_WORDS(MEM_WORDS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_result (result)
  );

  assign m_tdata = {7'b0, result};

endmodule

>>> design/lc3b_checker.sv
// Port-level assertions for the executor, bound to the top level.
`timescale 1ns / 1ps
`include "lc3b_instruction_executor_defines.svh"
module lc3b_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);
  `LC3B_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
  `LC3B_ASSERT_NOW(a_nzp, m_tvalid, $onehot(m_tdata[54:52]), "flags not one-hot")
  `LC3B_ASSERT_NOW(a_nowr, m_tvalid && !m_tdata[32], m_tdata[35:33] == 3'd0 && m_tdata[51:36] == 16'h0000, "register fields set without write")
  `LC3B_ASSERT_NOW(a_ill, m_tvalid && m_tdata[56], !m_tdata[32] && !m_tdata[55], "illegal step wrote or halted")
endmodule

bind lc3b_instruction_executor lc3b_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/lc3b_instruction_executor_tb.sv
// Testbench for the LC-3b instruction executor: shadow core, request driver, result checker.
`timescale 1ns / 1ps
module lc3b_instruction_executor_tb;
  import lc3b_pkg::*;

  localparam int MEM_WORDS = 32768;
  localparam int PHASE_ITEMS = 48;

  // Shadow LC-3b core; every accepted request updates it and queues the result
  // the block must return for that request.
  class lc3b_shadow_core;
    logic [15:0] mem [MEM_WORDS];
    logic [15:0] regs [8];
    logic [15:0] pc_q;
    logic [2:0]  nzp;
    logic        halt;
    result_t     pending_results [$];
    int          errors;

    function new();
      foreach (mem[i]) mem[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      pc_q = '0;
      nzp = FLAG_Z;
      halt = 1'b0;
      errors = 0;
    endfunction

    function automatic logic [15:0] sext(logic [15:0] v, int n);
      logic [15:0] m;
      m = (16'h1 << n) - 16'h1;
      return v[n-1] ? (v | ~m) : (v & m);
    endfunction

    function automatic logic [2:0] nzp_of(logic [15:0] v);
      if (v[15]) return FLAG_N;
      if (v == 16'h0) return FLAG_Z;
      return FLAG_P;
    endfunction

    function void load_start_pc(logic [15:0] v);
      pc_q = v;
      if (v != 16'h0) halt = 1'b0;
    endfunction

    function void accept_request(kind_t k, logic [14:0] wa, logic [15:0] wd);
      result_t r;
      logic [15:0] ir, inc, nxt, b, s, a, w, val;
      logic [3:0] op;
      logic [2:0] dr, sr;
      logic [1:0] mode;
      logic wr, setcc, ill;
      r = '0;
      wr = 1'b0;
      setcc = 1'b0;
      ill = 1'b0;
      val = '0;
      dr = '0;
      case (k)
        K_WRITE: mem[wa] = wd;
        K_READ:  r.read_data = mem[wa];
        K_STEP: begin
          if (halt || pc_q == 16'h0) begin
            halt = 1'b1;
          end else begin
            ir = mem[pc_q[15:1]];
            op = ir[15:12];
            dr = ir[11:9];
            sr = ir[8:6];
            inc = pc_q + 16'd2;
            nxt = inc;
            case (op)
              OP_ADD, OP_AND, OP_XOR: begin
                b = ir[5] ? sext(ir, 5) : regs[ir[2:0]];
                s = regs[sr];
                if (op == OP_ADD) val = s + b;
                else if (op == OP_AND) val = s & b;
                else val = s ^ b;
                wr = 1'b1;
                setcc = 1'b1;
              end
              OP_BR: if (ir[11:9] & nzp) nxt = inc + (sext(ir, 9) << 1);
              OP_JMP: nxt = regs[sr];
              OP_JSR: begin
                // target is taken before R7 is overwritten (JSRR R7)
                nxt = ir[11] ? inc + (sext(ir, 11) << 1) : regs[sr];
                val = inc;
                wr = 1'b1;
                dr = 3'd7;
              end
              OP_LDB: begin
                a = regs[sr] + sext(ir, 6);
                w = mem[a[15:1]];
                val = sext(a[0] ? {8'h0, w[15:8]} : {8'h0, w[7:0]}, 8);
                wr = 1'b1;
                setcc = 1'b1;
              end
              OP_LDW: begin
                a = regs[sr] + (sext(ir, 6) << 1);
                val = mem[a[15:1]];
                wr = 1'b1;
                setcc = 1'b1;
              end
              OP_LEA: begin
                val = inc + (sext(ir, 9) << 1);
                wr = 1'b1;
              end
              OP_RTI: ;
              OP_SHF: begin
                mode = ir[5:4];
                s = regs[sr];
                if (mode == SHF_KEEP) begin
                  nzp = nzp_of(regs[dr]);
                end else begin
                  if (mode == SHF_LSHF) val = s << ir[3:0];
                  else if (mode == SHF_RSHFL) val = s >> ir[3:0];
                  else val = $signed(s) >>> ir[3:0];
                  wr = 1'b1;
                  setcc = 1'b1;
                end
              end
              OP_STB: begin
                a = regs[sr] + sext(ir, 6);
                if (a[0]) mem[a[15:1]][15:8] = regs[dr][7:0];
                else mem[a[15:1]][7:0] = regs[dr][7:0];
              end
              OP_STW: begin
                a = regs[sr] + (sext(ir, 6) << 1);
                mem[a[15:1]] = regs[dr];
              end
              OP_TRAP: begin
                nxt = mem[{7'h0, ir[7:0]}];
                val = inc;
                wr = 1'b1;
                dr = 3'd7;
              end
              default: begin
                ill = 1'b1;
                nxt = pc_q;
              end
            endcase
            if (wr) regs[dr] = val;
            if (setcc) nzp = nzp_of(val);
            pc_q = nxt;
          end
        end
        default: ;
      endcase
      r.next_pc = pc_q;
      r.reg_written = wr;
      r.reg_index = wr ? dr : 3'd0;
      r.reg_value = wr ? val : 16'h0;
      r.cond_nzp = nzp;
      r.halted = halt;
      r.illegal = ill;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [63:0] beat);
      result_t got, want;
      got = result_t'(beat[56:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, beat);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data != want.read_data) begin
        $display("%0t: read_data exp %h got %h", $time, want.read_data, got.read_data);
        errors++;
      end
      if (got.next_pc != want.next_pc) begin
        $display("%0t: next_pc exp %h got %h", $time, want.next_pc, got.next_pc);
        errors++;
      end
      if (got.reg_written != want.reg_written) begin
        $display("%0t: reg_written exp %b got %b", $time, want.reg_written, got.reg_written);
        errors++;
      end
      if (got.reg_index != want.reg_index) begin
        $display("%0t: reg_index exp %0d got %0d", $time, want.reg_index, got.reg_index);
        errors++;
      end
      if (got.reg_value != want.reg_value) begin
        $display("%0t: reg_value exp %h got %h", $time, want.reg_value, got.reg_value);
        errors++;
      end
      if (got.cond_nzp != want.cond_nzp) begin
        $display("%0t: cond_nzp exp %b got %b", $time, want.cond_nzp, got.cond_nzp);
        errors++;
      end
      if (got.halted != want.halted) begin
        $display("%0t: halted exp %b got %b", $time, want.halted, got.halted);
        errors++;
      end
      if (got.illegal != want.illegal) begin
        $display("%0t: illegal exp %b got %b", $time, want.illegal, got.illegal);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // word_addr[14:0], write_data[30:15], zero fill
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // read_data, next_pc, reg_written, reg_index,
                               // reg_value, cond_nzp, halted, illegal, zero fill
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  lc3b_shadow_core core = new();

  bit tx_idle = 1'b1;   // sender inserts random gaps
  bit rx_idle = 1'b1;   // receiver drops tready at random
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off

  always #10 clk = ~clk;

  lc3b_instruction_executor #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Receiver: random back-pressure, plus a counted hold-off on request so the
  // front queue fills and s_tready drops.
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_idle || ($urandom_range(0, 99) >= 22);
    end
  end

  // Result beats are checked at the rising edge they are taken.
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) core.check_result(m_tdata);

  // Drive one request beat. Entered and left at a falling edge; tvalid stays
  // high on exit so back-to-back beats never toggle it within one step.
  task automatic send_request(input kind_t k, input logic [14:0] wa, input logic [15:0] wd);
    if (tx_idle && $urandom_range(0, 99) < 22) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {1'b0, wd, wa};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    core.accept_request(k, wa, wd);
    @(negedge clk);
  endtask

  // Plant an instruction at the current program counter, then run it.
  task automatic run_insn(input logic [3:0] op, input logic [11:0] rest);
    send_request(K_WRITE, core.pc_q[15:1], {op, rest});
    send_request(K_STEP, '0, '0);
  endtask

  // Let every outstanding result drain, then allow for the deepest latency.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (core.pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // start_pc write; only issued with no result outstanding.
  task automatic write_start_pc(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    core.load_start_pc(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int sent;
    int pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run_insn(4'($urandom_range(0, 15)), 12'($urandom));
        sent += 2;
      end else if (pick < 68) begin
        send_request(K_STEP, 15'($urandom), 16'($urandom));
        sent++;
      end else if (pick < 80) begin
        send_request(K_WRITE, 15'($urandom), 16'($urandom));
        sent++;
      end else if (pick < 95) begin
        // reads land near the program about half the time, else anywhere
        send_request(K_READ, pick[0] ? core.pc_q[15:1] + 15'($urandom_range(0, 3))
                                     : 15'($urandom), 16'($urandom));
        sent++;
      end else begin
        send_request(K_NOP, 15'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // start_pc at the low extreme: a step halts at once and stays halted
    write_start_pc(16'h0000);
    send_request(K_STEP, '0, '0);
    send_request(K_STEP, 15'h7FFF, 16'hFFFF);
    drain();

    // Directed program: every opcode, shift modes, odd byte access, traps,
    // reserved opcodes, JSRR through R7, then a jump to zero and halt.
    write_start_pc(16'h0100);
    send_request(K_WRITE, 15'h0025, 16'h0300);   // trap vector table entry
    run_insn(OP_ADD, 12'h27F);    // R1 = R1 + -1 (imm -1)
    run_insn(OP_ADD, 12'h46F);    // R2 = R1 + 15
    run_insn(OP_ADD, 12'h642);    // R3 = R1 + R2
    run_insn(OP_AND, 12'h8F0);    // R4 = R3 & -16
    run_insn(OP_XOR, 12'hA7F);    // R5 = ~R1
    run_insn(OP_LEA, 12'hD00);    // R6 = PC+2 - 512
    run_insn(OP_STW, 12'h39F);    // word store, positive offset
    run_insn(OP_LDW, 12'h19F);
    run_insn(OP_STB, 12'h3A1);    // odd byte
    run_insn(OP_LDB, 12'h5A1);    // sign-extended byte
    run_insn(OP_SHF, 12'h64F);    // LSHF by 15
    run_insn(OP_SHF, 12'h651);    // RSHFL by 1
    run_insn(OP_SHF, 12'h663);    // mode 10: flags only
    run_insn(OP_SHF, 12'h67F);    // RSHFA by 15
    run_insn(OP_BR,  12'hE00);    // always taken, offset 0
    run_insn(OP_BR,  12'h1FF);    // nzp clear, never taken
    run_insn(OP_JSR, 12'h801);
    run_insn(OP_JSR, 12'h1C0);    // JSRR R7
    run_insn(OP_TRAP, 12'h025);
    run_insn(OP_RTI, 12'h000);
    run_insn(OP_RSV0, 12'hFFF);
    run_insn(OP_RSV1, 12'h000);
    run_insn(OP_AND, 12'h020);    // R0 = 0
    run_insn(OP_JMP, 12'h000);    // PC = R0 = 0
    send_request(K_STEP, '0, '0);
    drain();

    // start_pc at the high extreme: odd fetch address
    write_start_pc(16'hFFFF);
    random_phase(PHASE_ITEMS);
    drain();

    // long stretch with no idling on either side
    write_start_pc(16'h4000);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_phase(PHASE_ITEMS);
    drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // receiver holds off while the sender keeps offering beats
    write_start_pc(16'($urandom_range(1, 65535)));
    hold_req = 1'b1;
    random_phase(PHASE_ITEMS);
    drain();

    // sender pauses mid-phase until every result is back
    write_start_pc(16'($urandom_range(1, 65535)));
    random_phase(PHASE_ITEMS / 2);
    drain();
    random_phase(PHASE_ITEMS / 2);
    drain();

    repeat (4) begin
      write_start_pc(16'($urandom_range(1, 65535)));
      random_phase(PHASE_ITEMS);
      drain();
    end

    if (core.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: covers the reset sweep of the memory and all phases many times over.
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
